// ===== hdl/page_frame_allocator_assert.svh =====
// Assertion macros used by the allocator RTL.
`ifndef PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pfa_pkg.sv =====
`timescale 1ns / 1ps
package pfa_pkg;

  localparam int PAGE_BYTES  = 4096;
  localparam int STACK_DEPTH = 4096;
  localparam int ADDR_BITS   = 32;
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int PN_W        = ADDR_BITS - PAGE_SHIFT;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OOM     = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_KERNEL_END   = 2'd0,
    CFG_PHYS_TOP     = 2'd1,
    CFG_REGION_START = 2'd2,
    CFG_REGION_END   = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Page number of an address rounded up to a page, wrapping at the top.
  function automatic logic [PN_W-1:0] round_up_pn(logic [ADDR_BITS-1:0] a);
    return a[ADDR_BITS-1:PAGE_SHIFT] + PN_W'(a[PAGE_SHIFT-1:0] != '0);
  endfunction

endpackage

// ===== hdl/pfa_ram.sv =====
`timescale 1ns / 1ps
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/page_frame_allocator.sv =====
// The result strobe (done) and the result are registered at the end of the
// execute state, which the accepting edge enters.
// No new request is accepted while busy; busy covers the execute state, which
// waits on the registered read of the free-page stack RAM.
// Reset (rst, synchronous): registers take their reset values, the stack is
// emptied and the bump pointer returns to page 0. Stack RAM is not cleared.
`timescale 1ns / 1ps
`include "page_frame_allocator_assert.svh"
module page_frame_allocator import pfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 command,
  input  logic [ADDR_BITS-1:0] address,
  output logic                 done,
  output logic [1:0]           status,
  output logic [ADDR_BITS-1:0] page_address,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [ADDR_BITS-1:0] cfg_data
);

  state_t state, state_next;

  logic [ADDR_BITS-1:0] kernel_end, kernel_end_next;
  logic [ADDR_BITS-1:0] phys_top, phys_top_next;
  logic [PN_W-1:0]      end_pn, end_pn_next;
  logic [PN_W-1:0]      fresh_pn, fresh_pn_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [CNT_W-1:0]     cnt_dec;

  cmd_t                 cmd_q;
  logic [ADDR_BITS-1:0] addr_q;

  logic                 we;
  logic [PN_W-1:0]      rdata;

  status_t              res_status;
  logic [ADDR_BITS-1:0] res_addr;
  logic                 accept;
  logic                 cfg_wr;

  assign accept  = start && !busy;
  assign cfg_wr  = cfg_valid && cfg_ready;
  assign cnt_dec = count - CNT_W'(1);

  // The top entry is read continuously; it is stable by the execute cycle.
  pfa_ram #(
    .WIDTH (PN_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (count[SP_W-1:0]),
    .wdata (addr_q[ADDR_BITS-1:PAGE_SHIFT]),
    .raddr (cnt_dec[SP_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state == S_EXEC);
    cfg_ready = (state == S_IDLE);
  end

  always_comb begin
    count_next      = count;
    fresh_pn_next   = fresh_pn;
    kernel_end_next = kernel_end;
    phys_top_next   = phys_top;
    end_pn_next     = end_pn;
    we              = 1'b0;
    res_status      = STAT_OK;
    res_addr        = '0;

    if (state == S_EXEC) begin
      if (cmd_q == CMD_ALLOC) begin
        priority if (count != '0) begin
          count_next = cnt_dec;
          res_addr   = {rdata, PAGE_SHIFT'(0)};
        end else if (fresh_pn < end_pn) begin
          res_addr      = {fresh_pn, PAGE_SHIFT'(0)};
          fresh_pn_next = fresh_pn + PN_W'(1);
        end else begin
          res_status = STAT_OOM;
        end
      end else begin
        priority if (addr_q[PAGE_SHIFT-1:0] != '0 || addr_q < kernel_end ||
                     addr_q >= phys_top) begin
          res_status = STAT_INVALID;
        end else if (count >= CNT_W'(STACK_DEPTH)) begin
          res_status = STAT_FULL;
        end else begin
          we         = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
    end

    if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KERNEL_END: kernel_end_next = cfg_data;
        CFG_PHYS_TOP:   phys_top_next   = cfg_data;
        CFG_REGION_START: begin
          count_next    = '0;
          fresh_pn_next = round_up_pn(cfg_data);
        end
        CFG_REGION_END: end_pn_next = round_up_pn(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      fresh_pn   <= '0;
      kernel_end <= '0;
      phys_top   <= '1;
      end_pn     <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      fresh_pn   <= fresh_pn_next;
      kernel_end <= kernel_end_next;
      phys_top   <= phys_top_next;
      end_pn     <= end_pn_next;
      done       <= (state == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd_t'(command);
      addr_q <= address;
    end
    if (state == S_EXEC) begin
      status       <= res_status;
      page_address <= res_addr;
    end
  end

  `PFA_ASSERT_NEXT(a_accept_exec, accept, busy, "accepted request did not enter execute")
  `PFA_ASSERT_NEXT(a_exec_done, busy, done && !busy, "execute cycle gave no result strobe")
  `PFA_ASSERT_NOW(a_count_range, 1'b1, count <= CNT_W'(STACK_DEPTH), "stack count past depth")
  `PFA_ASSERT_NOW(a_fail_zero, done && status != STAT_OK, page_address == '0,
                  "failed request returned a non-zero address")

endmodule

// ===== dv/page_frame_allocator_checker.sv =====
`timescale 1ns / 1ps
module page_frame_allocator_checker import pfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 command,
  input  logic [ADDR_BITS-1:0] address,
  input  logic                 done,
  input  logic [1:0]           status,
  input  logic [ADDR_BITS-1:0] page_address,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [ADDR_BITS-1:0] cfg_data,
  output int                   failures,
  output int                   pending
);

  typedef struct packed {
    status_t              st;
    logic [ADDR_BITS-1:0] pa;
  } grant_t;

  grant_t               grants_due[$];
  logic [ADDR_BITS-1:0] kern_lim;
  logic [ADDR_BITS-1:0] top_lim;
  logic [ADDR_BITS-1:0] fresh_end;
  logic [ADDR_BITS-1:0] bump;
  logic [PN_W-1:0]      freed_pages [STACK_DEPTH];
  int unsigned          freed_count;

  // Round up to a page boundary; the top partial page wraps to zero.
  function automatic logic [ADDR_BITS-1:0] page_ceil(logic [ADDR_BITS-1:0] a);
    logic [ADDR_BITS-1:0] base;
    base = a & ~ADDR_BITS'(PAGE_BYTES - 1);
    return (a == base) ? a : base + ADDR_BITS'(PAGE_BYTES);
  endfunction

  function automatic grant_t serve_request(cmd_t c, logic [ADDR_BITS-1:0] a);
    grant_t g;
    g.st = STAT_OK;
    g.pa = '0;
    if (c == CMD_ALLOC) begin
      if (freed_count != 0) begin
        freed_count--;
        g.pa = {freed_pages[freed_count], {PAGE_SHIFT{1'b0}}};
      end else if (bump < page_ceil(fresh_end)) begin
        g.pa = bump;
        bump = bump + ADDR_BITS'(PAGE_BYTES);
      end else begin
        g.st = STAT_OOM;
      end
    end else if (a[PAGE_SHIFT-1:0] != '0 || a < kern_lim || a >= top_lim) begin
      g.st = STAT_INVALID;
    end else if (freed_count >= STACK_DEPTH) begin
      g.st = STAT_FULL;
    end else begin
      freed_pages[freed_count] = a[ADDR_BITS-1:PAGE_SHIFT];
      freed_count++;
    end
    return g;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (rst) begin
      kern_lim    = '0;
      top_lim     = '1;
      fresh_end   = '0;
      bump        = page_ceil('0);
      freed_count = 0;
      grants_due.delete();
    end else begin
      if (done) begin
        if (grants_due.size() == 0) begin
          failures++;
          $display("%0t: result with nothing outstanding: expected none, %s %0d %s %h",
                   $time, "got status", status, "page_address", page_address);
        end else begin
          want = grants_due.pop_front();
          if (status !== want.st) begin
            failures++;
            $display("%0t: status mismatch: expected %0d, got %0d", $time, want.st, status);
          end
          if (page_address !== want.pa) begin
            failures++;
            $display("%0t: page_address mismatch: expected %h, got %h",
                     $time, want.pa, page_address);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_KERNEL_END: kern_lim = cfg_data;
          CFG_PHYS_TOP:   top_lim  = cfg_data;
          CFG_REGION_START: begin
            // new region: stack dropped, bump pointer reloaded
            freed_count = 0;
            bump        = page_ceil(cfg_data);
          end
          CFG_REGION_END: fresh_end = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        grants_due.push_back(serve_request(cmd_t'(command), address));
    end
    pending = grants_due.size();
  end

endmodule

// ===== dv/page_frame_allocator_tb.sv =====
`timescale 1ns / 1ps
module page_frame_allocator_tb;
  import pfa_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int SEGMENTS     = 6;
  localparam int SETTLE       = 6;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 command;
  logic [ADDR_BITS-1:0] address;
  logic                 done;
  logic [1:0]           status;
  logic [ADDR_BITS-1:0] page_address;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [ADDR_BITS-1:0] cfg_data;
  int                   failures;
  int                   pending;
  int                   idle_pct;
  logic [ADDR_BITS-1:0] kern_lim;
  logic [ADDR_BITS-1:0] top_lim;

  page_frame_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .address      (address),
    .done         (done),
    .status       (status),
    .page_address (page_address),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  page_frame_allocator_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .address      (address),
    .done         (done),
    .status       (status),
    .page_address (page_address),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .failures     (failures),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(cmd_t c, logic [ADDR_BITS-1:0] a);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    start   <= 1'b1;
    command <= c;
    address <= a;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Wait for every outstanding transaction to complete, then let the block settle.
  task automatic wait_quiet();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [ADDR_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_regs(logic [ADDR_BITS-1:0] k, logic [ADDR_BITS-1:0] t,
                              logic [ADDR_BITS-1:0] s, logic [ADDR_BITS-1:0] e);
    write_reg(CFG_KERNEL_END, k);
    write_reg(CFG_PHYS_TOP, t);
    write_reg(CFG_REGION_START, s);
    write_reg(CFG_REGION_END, e);
    cfg_valid <= 1'b0;
    kern_lim  = k;
    top_lim   = t;
  endtask

  // Mostly aligned pages inside the freeable window; the rest are random, below kern_lim or at or above top_lim.
  function automatic logic [ADDR_BITS-1:0] pick_free_address();
    logic [PN_W:0]        lo_pn;
    logic [PN_W:0]        hi_pn;
    logic [ADDR_BITS-1:0] pn;
    int                   r;
    r     = $urandom_range(0, 99);
    lo_pn = {1'b0, kern_lim[ADDR_BITS-1:PAGE_SHIFT]}
            + (PN_W+1)'(|kern_lim[PAGE_SHIFT-1:0]);
    hi_pn = {1'b0, top_lim[ADDR_BITS-1:PAGE_SHIFT]}
            - (PN_W+1)'(top_lim[PAGE_SHIFT-1:0] == '0);
    if (r < 75 && top_lim != '0 && lo_pn <= hi_pn) begin
      pn = $urandom_range(hi_pn, lo_pn);
      return {pn[PN_W-1:0], {PAGE_SHIFT{1'b0}}};
    end
    case (r % 3)
      0:       return $urandom();
      1:       return (kern_lim != '0) ? $urandom_range(kern_lim - 1, 0)
                                       & ~ADDR_BITS'(PAGE_BYTES - 1) : $urandom();
      default: return $urandom_range(32'hFFFF_FFFF, top_lim);
    endcase
  endfunction

  initial begin
    logic [ADDR_BITS-1:0] k;
    logic [ADDR_BITS-1:0] t;
    logic [ADDR_BITS-1:0] s;
    logic [ADDR_BITS-1:0] e;
    int                   free_pct;
    rst       <= 1'b1;
    start     <= 1'b0;
    command   <= CMD_ALLOC;
    address   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_KERNEL_END;
    cfg_data  <= '0;
    kern_lim  = '0;
    top_lim   = '1;
    idle_pct  = 10;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults: no fresh region, whole address space freeable
    send_request(CMD_ALLOC, 32'hFFFF_FFFF);
    send_request(CMD_FREE, 32'h0000_0001);
    send_request(CMD_FREE, 32'hFFFF_FFFF);
    send_request(CMD_FREE, 32'h0000_0000);
    send_request(CMD_FREE, 32'hFFFF_F000);
    send_request(CMD_FREE, 32'hFFFF_F000);      // double free goes through
    send_request(CMD_ALLOC, 32'h0);
    send_request(CMD_ALLOC, 32'h0);
    send_request(CMD_ALLOC, 32'h0);
    send_request(CMD_ALLOC, 32'h0);
    wait_quiet();

    // narrow window, unaligned region bounds round up
    program_regs(32'h0001_0000, 32'h0002_0000, 32'h0000_3001, 32'h0000_5800);
    send_request(CMD_FREE, 32'h0000_F000);
    send_request(CMD_FREE, 32'h0002_0000);
    send_request(CMD_FREE, 32'h0001_F000);
    send_request(CMD_FREE, 32'h0001_0000);
    repeat (5) send_request(CMD_ALLOC, $urandom());
    wait_quiet();

    // region bounds in the top partial page wrap to zero
    program_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_F001, 32'hFFFF_FFFF);
    send_request(CMD_ALLOC, 32'h0);
    send_request(CMD_FREE, 32'h0000_0000);
    send_request(CMD_FREE, 32'hFFFF_F000);
    wait_quiet();
    program_regs(32'h0, 32'hFFFF_FFFF, 32'hFFFF_E000, 32'hFFFF_EFFF);
    send_request(CMD_ALLOC, 32'h0);
    send_request(CMD_ALLOC, 32'h0);
    wait_quiet();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      idle_pct = (seg < 2) ? 10 : (seg < 4) ? 69 : 0;
      case (seg)
        0: program_regs(32'h0010_0000, 32'h0800_0000, 32'h0020_0001, 32'h0024_0000);
        1: program_regs(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        2: program_regs(32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'hFFFF_F000);
        4: program_regs(32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0FFF, 32'h0001_0001);
        default: begin
          k = $urandom();
          t = $urandom();
          if (k > t) begin
            s = k;
            k = t;
            t = s;
          end
          s = $urandom();
          e = s + $urandom_range(32'h0004_0000, 0);
          program_regs(k, t, s, e);
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / SEGMENTS; n++) begin
        // free-heavy first half grows the stack, alloc-heavy second half drains it
        free_pct = (n < RANDOM_ITEMS / SEGMENTS / 2) ? 65 : 35;
        if ($urandom_range(0, 99) < free_pct)
          send_request(CMD_FREE, pick_free_address());
        else
          send_request(CMD_ALLOC, $urandom());
      end
      wait_quiet();
    end

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
